// ===== hw/rtl/dbf_pkg.sv =====
package dbf_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int OPC_W           = 2;
    localparam int IDX_W           = 10;
    localparam int CNT_W           = 11;
    localparam int WORD_W          = 16;
    localparam int NAME_W          = 3 * WORD_W;
    localparam int BLK_W           = 16;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [BLK_W-1:0]  blocks;
        logic              perm;
    } entry_t;

endpackage

// ===== hw/rtl/directory_delete_best_fit_core.sv =====
// Load, clear and unused-opcode words: result strobed on done the next cycle; busy
// stays low, so one such word per cycle.
// Query word: sweeps n = min(entry_count, MAX_ENTRIES) entries, one per cycle through the
// single read port; result on done after the last entry (next cycle if n is 0), busy high till then.
// Results cannot be stalled. Async active-low reset clears totals, entry_count and
// control; table contents are left as they are.
module directory_delete_best_fit_core #(
    parameter int MAX_ENTRIES = dbf_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dbf_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [dbf_pkg::OPC_W-1:0]   opcode,
    input  logic [dbf_pkg::IDX_W-1:0]   entry_index,
    input  logic [dbf_pkg::WORD_W-1:0]  name_word0,
    input  logic [dbf_pkg::WORD_W-1:0]  name_word1,
    input  logic [dbf_pkg::WORD_W-1:0]  name_word2,
    input  logic [dbf_pkg::BLK_W-1:0]   entry_blocks,
    input  logic                        entry_permanent,
    input  logic [dbf_pkg::BLK_W-1:0]   wanted_blocks,
    output logic                        done,
    output logic                        fit_found,
    output logic [dbf_pkg::IDX_W-1:0]   fit_index,
    output logic [dbf_pkg::BLK_W-1:0]   fit_blocks,
    output logic                        deleted_any,
    output logic [dbf_pkg::BLK_W-1:0]   used_total,
    output logic [dbf_pkg::BLK_W-1:0]   free_total
);
    import dbf_pkg::*;

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int NW  = $clog2(MAX_ENTRIES + 1);
    localparam int CW  = (CNT_W > NW) ? CNT_W : NW;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BLK_W-1:0]  used_reg, used_next;
    logic [BLK_W-1:0]  free_reg, free_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [NAME_W-1:0] name_reg, name_next;
    logic [BLK_W-1:0]  want_reg, want_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [BLK_W-1:0]  best_size_reg, best_size_next;
    logic              del_reg, del_next;
    logic              done_reg, done_next;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;
    logic [CW-1:0]     n_lim;
    logic              hit;
    logic              fits;
    op_t               op;

    assign op    = op_t'(opcode);
    assign n_lim = (CW'(count_reg) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_reg);
    assign hit   = rd_data_reg.perm && (rd_data_reg.name == name_reg);
    assign fits  = (!rd_data_reg.perm || hit) && (want_reg <= rd_data_reg.blocks)
                   && (!found_reg || (rd_data_reg.blocks < best_size_reg));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        name_next      = name_reg;
        want_next      = want_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        del_next       = del_reg;
        done_next      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data_reg;

        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    found_next     = 1'b0;
                    best_idx_next  = '0;
                    best_size_next = '0;
                    del_next       = 1'b0;
                    case (op)
                        OP_LOAD:
                        begin
                            if (int'(entry_index) < MAX_ENTRIES)
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = AW'(entry_index);
                                wr_data.name   = {name_word2, name_word1, name_word0};
                                wr_data.blocks = entry_blocks;
                                wr_data.perm   = entry_permanent;
                                if (entry_permanent)
                                    used_next = used_reg + entry_blocks;
                                else
                                    free_next = free_reg + entry_blocks;
                            end
                            done_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            used_next = '0;
                            free_next = '0;
                            done_next = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            name_next = {name_word2, name_word1, name_word0};
                            want_next = wanted_blocks;
                            n_next    = n_lim;
                            idx_next  = '0;
                            if (n_lim == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SWEEP;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (hit)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg[AW-1:0];
                    wr_data.perm = 1'b0;
                    del_next     = 1'b1;
                    free_next    = free_reg + rd_data_reg.blocks;
                    used_next    = used_reg - rd_data_reg.blocks;
                end
                if (fits)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = idx_reg[AW-1:0];
                    best_size_next = rd_data_reg.blocks;
                end
                if (idx_reg == n_reg - CW'(1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_next[AW-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            free_reg      <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_size_reg <= '0;
            del_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_size_reg <= best_size_next;
            del_reg       <= del_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_reg <= name_next;
        want_reg <= want_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign busy        = (state_reg == ST_SWEEP);
    assign done        = done_reg;
    assign fit_found   = found_reg;
    assign fit_index   = IDX_W'(best_idx_reg);
    assign fit_blocks  = best_size_reg;
    assign deleted_any = del_reg;
    assign used_total  = used_reg;
    assign free_total  = free_reg;

endmodule

// ===== hw/rtl/dbf_checker.sv =====
module dbf_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [dbf_pkg::OPC_W-1:0]   opcode,
    input  logic                        done,
    input  logic                        fit_found,
    input  logic [dbf_pkg::IDX_W-1:0]   fit_index,
    input  logic [dbf_pkg::BLK_W-1:0]   fit_blocks,
    input  logic                        deleted_any,
    input  logic [dbf_pkg::BLK_W-1:0]   used_total,
    input  logic [dbf_pkg::BLK_W-1:0]   free_total
);
    import dbf_pkg::*;

    logic take_short;

    assign take_short = start && !busy && (opcode != OP_QUERY);

    // non-query words strobe done in the next cycle
    a_short_done: assert property (@(posedge clk) disable iff (!rst_n)
        take_short |=> done)
        else $error("non-query word gave no result");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        take_short |=> (!fit_found && !deleted_any && fit_index == '0 && fit_blocks == '0))
        else $error("non-query word reported a fit or delete");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_CLEAR) |=> (used_total == '0 && free_total == '0))
        else $error("clear left totals nonzero");

    a_no_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !fit_found) |-> (fit_index == '0 && fit_blocks == '0))
        else $error("fit fields set without a fit");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

endmodule

bind directory_delete_best_fit_core dbf_checker u_dbf_checker (.*);

// ===== tb/directory_delete_best_fit_core_tb.sv =====
`timescale 1ns / 100ps

module directory_delete_best_fit_core_tb;

    import dbf_pkg::*;

    localparam int STALL_LIMIT = 8000;
    localparam int RANDOM_WORDS = 560;
    localparam logic [NAME_W-1:0] NAME_ZERO = 48'h0000_0000_0000;
    localparam logic [NAME_W-1:0] NAME_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [NAME_W-1:0] NAME_A    = 48'h0003_0002_0001;
    localparam logic [NAME_W-1:0] NAME_B    = 48'h2000_4000_8000;

    typedef struct packed {
        logic              fit_found;
        logic [IDX_W-1:0]  fit_index;
        logic [BLK_W-1:0]  fit_blocks;
        logic              deleted_any;
        logic [BLK_W-1:0]  used_tot;
        logic [BLK_W-1:0]  free_tot;
    } result_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CNT_W-1:0]  cfg_val;
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [NAME_W-1:0] nm;
        logic [BLK_W-1:0]  blk;
        logic              perm;
        logic [BLK_W-1:0]  want;
        logic              typed;
        result_t           res;
    } stim_row_t;

    localparam result_t RES_ZERO      = '0;
    localparam result_t RES_USED_FULL = '{1'b0, 10'd0, 16'h0000, 1'b0, 16'hFFFF, 16'h0000};

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_wdata;
    logic               start;
    logic               busy;
    logic [OPC_W-1:0]   opcode;
    logic [IDX_W-1:0]   entry_index;
    logic [WORD_W-1:0]  name_word0;
    logic [WORD_W-1:0]  name_word1;
    logic [WORD_W-1:0]  name_word2;
    logic [BLK_W-1:0]   entry_blocks;
    logic               entry_permanent;
    logic [BLK_W-1:0]   wanted_blocks;
    logic               done;
    logic               fit_found;
    logic [IDX_W-1:0]   fit_index;
    logic [BLK_W-1:0]   fit_blocks;
    logic               deleted_any;
    logic [BLK_W-1:0]   used_total;
    logic [BLK_W-1:0]   free_total;

    // predicted directory state
    logic [NAME_W-1:0]  dir_name [MAX_ENTRIES_DEF];
    logic [BLK_W-1:0]   dir_size [MAX_ENTRIES_DEF];
    logic               dir_perm [MAX_ENTRIES_DEF];
    logic [BLK_W-1:0]   used_sum;
    logic [BLK_W-1:0]   free_sum;
    logic [CNT_W-1:0]   sweep_limit;

    result_t            pending_results [$];
    result_t            cur_exp;
    result_t            head_r;
    result_t            pred_r;
    logic               cur_typed;
    bit                 slot_loaded [MAX_ENTRIES_DEF];
    logic [NAME_W-1:0]  name_pool [6];
    stim_row_t          stim_tab [24];
    int                 words_sent;
    int                 fill_words;
    int                 errors;
    int                 stall_cycles;

    directory_delete_best_fit_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .name_word0      (name_word0),
        .name_word1      (name_word1),
        .name_word2      (name_word2),
        .entry_blocks    (entry_blocks),
        .entry_permanent (entry_permanent),
        .wanted_blocks   (wanted_blocks),
        .done            (done),
        .fit_found       (fit_found),
        .fit_index       (fit_index),
        .fit_blocks      (fit_blocks),
        .deleted_any     (deleted_any),
        .used_total      (used_total),
        .free_total      (free_total)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // load/clear update the model; query deletes matching permanent entries, picks smallest adequate empty entry
    function automatic result_t apply_word(op_t op, logic [IDX_W-1:0] ix,
                                           logic [NAME_W-1:0] nm, logic [BLK_W-1:0] blk,
                                           logic perm, logic [BLK_W-1:0] want);
        result_t r;
        int      n;
        r = '0;
        case (op)
            OP_LOAD:
            begin
                dir_name[ix] = nm;
                dir_size[ix] = blk;
                dir_perm[ix] = perm;
                if (perm)
                    used_sum = used_sum + blk;
                else
                    free_sum = free_sum + blk;
            end
            OP_CLEAR:
            begin
                used_sum = '0;
                free_sum = '0;
            end
            OP_QUERY:
            begin
                n = (int'(sweep_limit) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(sweep_limit);
                for (int i = 0; i < n; i++)
                begin
                    if (dir_perm[i] && dir_name[i] == nm)
                    begin
                        dir_perm[i]   = 1'b0;
                        r.deleted_any = 1'b1;
                        free_sum      = free_sum + dir_size[i];
                        used_sum      = used_sum - dir_size[i];
                    end
                    if (!dir_perm[i] && want <= dir_size[i] &&
                        (!r.fit_found || dir_size[i] < r.fit_blocks))
                    begin
                        r.fit_found  = 1'b1;
                        r.fit_index  = IDX_W'(i);
                        r.fit_blocks = dir_size[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.used_tot = used_sum;
        r.free_tot = free_sum;
        return r;
    endfunction

    task automatic report(string field, longint e, longint g);
        errors++;
        if (errors < 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, g);
    endtask

    task automatic send_item(op_t op, logic [IDX_W-1:0] ix, logic [NAME_W-1:0] nm,
                             logic [BLK_W-1:0] blk, logic perm, logic [BLK_W-1:0] want,
                             logic typed, result_t exp_r);
        int idle_len;
        int rel;
        idle_len = 0;
        rel = words_sent - fill_words;
        if (!(rel >= 300 && rel < 420) && $urandom_range(99) < 7)
            idle_len = $urandom_range(1, 3);
        @(negedge clk);
        if (idle_len > 0)
        begin
            start = 1'b0;
            repeat (idle_len) @(negedge clk);
        end
        opcode          = op;
        entry_index     = ix;
        name_word0      = nm[15:0];
        name_word1      = nm[31:16];
        name_word2      = nm[47:32];
        entry_blocks    = blk;
        entry_permanent = perm;
        wanted_blocks   = want;
        cur_typed       = typed;
        cur_exp         = exp_r;
        start           = 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_LOAD)
            slot_loaded[ix] = 1'b1;
        words_sent++;
    endtask

    task automatic send_random(op_t op, logic [IDX_W-1:0] ix);
        logic [NAME_W-1:0] nm;
        logic [BLK_W-1:0]  blk;
        logic [BLK_W-1:0]  want;
        int                pick;
        if ($urandom_range(99) < 85)
            nm = name_pool[$urandom_range(0, 5)];
        else
            nm = {16'($urandom), 32'($urandom)};
        pick = $urandom_range(99);
        if (pick < 60)
            blk = 16'($urandom_range(0, 40));
        else if (pick < 70)
            blk = 16'($urandom_range(16'hFF00, 16'hFFFF));
        else
            blk = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 50)
            want = 16'($urandom_range(0, 40));
        else if (pick < 60)
            want = 16'h0000;
        else if (pick < 70)
            want = 16'hFFFF;
        else
            want = 16'($urandom);
        send_item(op, ix, nm, blk, ($urandom_range(99) < 60), want, 1'b0, RES_ZERO);
    endtask

    // only while idle: every outstanding word has returned
    task automatic set_count(logic [CNT_W-1:0] v);
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report("unexpected result, used_total", 0, used_total);
                end
                else
                begin
                    head_r = pending_results.pop_front();
                    if (fit_found !== head_r.fit_found)
                        report("fit_found", head_r.fit_found, fit_found);
                    if (fit_index !== head_r.fit_index)
                        report("fit_index", head_r.fit_index, fit_index);
                    if (fit_blocks !== head_r.fit_blocks)
                        report("fit_blocks", head_r.fit_blocks, fit_blocks);
                    if (deleted_any !== head_r.deleted_any)
                        report("deleted_any", head_r.deleted_any, deleted_any);
                    if (used_total !== head_r.used_tot)
                        report("used_total", head_r.used_tot, used_total);
                    if (free_total !== head_r.free_tot)
                        report("free_total", head_r.free_tot, free_total);
                end
            end
            if (cfg_we)
                sweep_limit = cfg_wdata;
            if (start && !busy)
            begin
                pred_r = apply_word(op_t'(opcode), entry_index,
                                    {name_word2, name_word1, name_word0},
                                    entry_blocks, entry_permanent, wanted_blocks);
                pending_results.push_back(cur_typed ? cur_exp : pred_r);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int                n;
        int                m;
        int                c;
        int                pfx;
        int                pick;
        int                w0;
        int                phase_no;
        bit                big_done;
        logic [IDX_W-1:0]  ix;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        start           = 1'b0;
        opcode          = OP_LOAD;
        entry_index     = '0;
        name_word0      = '0;
        name_word1      = '0;
        name_word2      = '0;
        entry_blocks    = '0;
        entry_permanent = 1'b0;
        wanted_blocks   = '0;
        cur_typed       = 1'b0;
        cur_exp         = RES_ZERO;
        used_sum        = '0;
        free_sum        = '0;
        sweep_limit     = '0;
        words_sent      = 0;
        fill_words      = 0;
        errors          = 0;
        stall_cycles    = 0;
        phase_no        = 0;
        big_done        = 1'b0;
        foreach (slot_loaded[i])
            slot_loaded[i] = 1'b0;
        name_pool[0] = NAME_ZERO;
        name_pool[1] = NAME_ONES;
        for (int i = 2; i < 6; i++)
            name_pool[i] = {16'($urandom), 32'($urandom)};

        stim_tab = '{
            '{1'b0, 11'd0, OP_QUERY, 10'd0,   NAME_ZERO, 16'h0000, 1'b0, 16'h0000, 1'b1, RES_ZERO},
            '{1'b0, 11'd0, OP_NOP,   10'h3FF, NAME_ONES, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, RES_ZERO},
            '{1'b0, 11'd0, OP_CLEAR, 10'h155, NAME_A,    16'h1234, 1'b1, 16'h00FF, 1'b1, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd0,   NAME_A,    16'hFFFF, 1'b1, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd1,   NAME_A,    16'h0005, 1'b1, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd2,   NAME_ONES, 16'h000A, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd3,   NAME_ZERO, 16'h000A, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd4,   NAME_B,    16'h0000, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd5,   NAME_B,    16'h0003, 1'b1, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd6,   NAME_ONES, 16'hFFFF, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'd7,   NAME_ONES, 16'h0007, 1'b1, 16'h0000, 1'b0, RES_ZERO},
            '{1'b1, 11'd8, OP_NOP,   10'd0,   NAME_ZERO, 16'h0000, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_QUERY, 10'd0,   NAME_A,    16'h0000, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_QUERY, 10'd0,   NAME_A,    16'h0000, 1'b0, 16'h0006, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_QUERY, 10'd0,   NAME_ZERO, 16'h0000, 1'b0, 16'hFFFF, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_QUERY, 10'd0,   NAME_ONES, 16'h0000, 1'b0, 16'h000B, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_CLEAR, 10'd0,   NAME_ZERO, 16'h0000, 1'b0, 16'h0000, 1'b1, RES_ZERO},
            '{1'b0, 11'd0, OP_LOAD,  10'h3FF, NAME_ONES, 16'hFFFF, 1'b1, 16'h0000, 1'b1,
              RES_USED_FULL},
            '{1'b0, 11'd0, OP_LOAD,  10'h3FF, NAME_B,    16'h0001, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b1, 11'd0, OP_NOP,   10'd0,   NAME_ZERO, 16'h0000, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_QUERY, 10'd0,   NAME_ONES, 16'h0000, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b1, 11'd8, OP_NOP,   10'd0,   NAME_ZERO, 16'h0000, 1'b0, 16'h0000, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_QUERY, 10'd0,   NAME_B,    16'h0000, 1'b0, 16'h0001, 1'b0, RES_ZERO},
            '{1'b0, 11'd0, OP_NOP,   10'd0,   NAME_ZERO, 16'h0000, 1'b0, 16'h0000, 1'b0, RES_ZERO}
        };

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_tab[r])
        begin
            if (stim_tab[r].is_cfg)
                set_count(stim_tab[r].cfg_val);
            else
                send_item(stim_tab[r].op, stim_tab[r].idx, stim_tab[r].nm, stim_tab[r].blk,
                          stim_tab[r].perm, stim_tab[r].want, stim_tab[r].typed,
                          stim_tab[r].res);
        end

        while (words_sent - fill_words < RANDOM_WORDS)
        begin
            if (!big_done && phase_no == 3)
            begin
                // whole table loaded once so full-depth sweeps are legal
                w0 = words_sent;
                send_random(OP_CLEAR, 10'($urandom));
                for (int i = 0; i < MAX_ENTRIES_DEF; i++)
                    send_random(OP_LOAD, IDX_W'(i));
                fill_words = words_sent - w0;
                set_count(11'd2047);
                repeat (3) send_random(OP_QUERY, 10'($urandom));
                set_count(11'd1024);
                repeat (2) send_random(OP_QUERY, 10'($urandom));
                big_done = 1'b1;
            end
            else
            begin
                if ($urandom_range(1) == 1)
                    send_random(OP_CLEAR, 10'($urandom));
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    send_random(OP_LOAD, IDX_W'(i));
                pfx = 0;
                while (pfx < MAX_ENTRIES_DEF && slot_loaded[pfx])
                    pfx++;
                if (big_done)
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        c = $urandom_range(1025, 2047);
                    else if (pick < 10)
                        c = MAX_ENTRIES_DEF;
                    else
                        c = $urandom_range(0, 40);
                end
                else
                begin
                    c = $urandom_range(0, pfx);
                end
                set_count(11'(c));
                m = $urandom_range(8, 24);
                repeat (m)
                begin
                    pick = $urandom_range(99);
                    if (pick < 65)
                    begin
                        send_random(OP_QUERY, 10'($urandom));
                    end
                    else if (pick < 80)
                    begin
                        if ($urandom_range(1) == 1)
                            ix = 10'($urandom_range(0, n - 1));
                        else
                            ix = 10'($urandom);
                        send_random(OP_LOAD, ix);
                    end
                    else if (pick < 90)
                    begin
                        send_random(OP_NOP, 10'($urandom));
                    end
                    else
                    begin
                        send_random(OP_CLEAR, 10'($urandom));
                    end
                end
            end
            phase_no++;
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dbf_pkg.sv
hw/rtl/directory_delete_best_fit_core.sv
hw/rtl/dbf_checker.sv
tb/directory_delete_best_fit_core_tb.sv
